// ===== rtl/go_back_n_sender_rtt_unit_defines.svh =====
// Assertion macros shared by the go-back-n sender RTL.
`ifndef GO_BACK_N_SENDER_RTT_UNIT_DEFINES_SVH
`define GO_BACK_N_SENDER_RTT_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is asserted
`define GBN_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (prop)) \
        else $error("gbn assertion failed");
// next-cycle implication, disabled while reset is asserted
`define GBN_ASSERT_NXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (prop)) \
        else $error("gbn assertion failed");
`else
`define GBN_ASSERT_IMP(label, clk, rst_n, cond, prop)
`define GBN_ASSERT_NXT(label, clk, rst_n, cond, prop)
`endif
`endif

// ===== rtl/gbn_pkg.sv =====
// Types and constants shared by the go-back-n sender modules.
`default_nettype none

package gbn_pkg;

    // field widths
    localparam int SEQ_W      = 32;
    localparam int TMO_OUT_W  = 24;
    localparam int FLIGHT_W   = 7;

    // event opcodes
    localparam logic [1:0] OP_OFFER = 2'd0;
    localparam logic [1:0] OP_ACK   = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // result kinds
    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_NEW    = 3'd1;
    localparam logic [2:0] KIND_RESEND = 3'd2;
    localparam logic [2:0] KIND_FULL   = 3'd3;
    localparam logic [2:0] KIND_ABORT  = 3'd4;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIXED   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DYNAMIC = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIALS  = 2'd3;

    // register reset values
    localparam logic [FLIGHT_W-1:0] RST_WINDOW    = 7'd8;
    localparam logic [15:0]         RST_FIXED     = 16'd50;
    localparam logic [7:0]          RST_TRIALS    = 8'd10;
    localparam logic [15:0]         START_TIMEOUT = 16'd50;

    // event queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [SEQ_W-1:0] ack_seq;
    } t_in_item;

    typedef struct packed {
        logic [2:0]           kind;
        logic [SEQ_W-1:0]     seq_out;
        logic                 last;
        logic [TMO_OUT_W-1:0] timeout_now;
        logic [FLIGHT_W-1:0]  in_flight;
    } t_out_item;

    // decoded event; no flag set means an unknown opcode
    typedef struct packed {
        logic             is_offer;
        logic             is_ack;
        logic             is_tick;
        logic [SEQ_W-1:0] ack_seq;
    } t_event;

    // head of the event queue as seen by the back end
    typedef struct packed {
        logic   vld;
        t_event ev;
    } t_queue_head;

endpackage

`default_nettype wire

// ===== rtl/gbn_front.sv =====
// Front end: decodes incoming events and queues them for the back end.
`default_nettype none

module gbn_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  gbn_pkg::t_in_item    i_in_data,
    output gbn_pkg::t_queue_head o_head,
    input  logic                 i_pop
);
    import gbn_pkg::*;

    t_event              w_ev;
    t_event              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr;
    logic [QPTR_W-1:0]   r_rd;
    logic [QCNT_W-1:0]   r_cnt;
    logic                w_push;
    logic                w_pop;

    // opcode decode
    always_comb begin
        w_ev.is_offer = (i_in_data.opcode == OP_OFFER);
        w_ev.is_ack   = (i_in_data.opcode == OP_ACK);
        w_ev.is_tick  = (i_in_data.opcode == OP_TICK);
        w_ev.ack_seq  = i_in_data.ack_seq;
    end

    assign o_in_stall = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign w_push     = i_in_valid && !o_in_stall;
    assign w_pop      = i_pop && (r_cnt != '0);

    assign o_head.vld = (r_cnt != '0);
    assign o_head.ev  = r_mem[r_rd];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= w_ev;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/gbn_back.sv =====
// Back end: window, timer, retry and RTT state; emits result transactions.
`default_nettype none

module gbn_back #(
    parameter int WINDOW_MAX = 64,
    parameter int TIMER_BITS = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  gbn_pkg::t_queue_head            i_head,
    output logic                            o_pop,
    input  logic                            i_cfg_we,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gbn_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output gbn_pkg::t_out_item              o_out_data
);
    import gbn_pkg::*;

    localparam int TW = TIMER_BITS;
    localparam int FW = TIMER_BITS + 3;
    localparam int RW = (FW > 19) ? FW : 19;
    localparam int EW = (TW > TMO_OUT_W) ? TW : TMO_OUT_W;
    localparam logic [FW-1:0]       FRAC_MAX  = {FW{1'b1}};
    localparam logic [TW-1:0]       TICK_MAX  = {TW{1'b1}};
    localparam logic [FLIGHT_W-1:0] WIN_LIMIT = FLIGHT_W'(WINDOW_MAX);

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EST    = 3'd1;
    localparam logic [2:0] ST_DIFF   = 3'd2;
    localparam logic [2:0] ST_DEV    = 3'd3;
    localparam logic [2:0] ST_TMO    = 3'd4;
    localparam logic [2:0] ST_ACKOUT = 3'd5;
    localparam logic [2:0] ST_RESEND = 3'd6;

    // start value of the timeout in eighths of a tick, saturated
    function automatic logic [FW-1:0] reload_value(input logic dyn, input logic [15:0] fixed);
        logic [RW-1:0] wide;
        wide = RW'({(dyn ? START_TIMEOUT : fixed), 3'b000});
        if (wide > RW'(FRAC_MAX)) begin
            reload_value = FRAC_MAX;
        end else begin
            reload_value = wide[FW-1:0];
        end
    endfunction

    // whole-tick view of the timeout, saturated to the output width
    function automatic logic [TMO_OUT_W-1:0] tmo_view(input logic [FW-1:0] t);
        logic [EW-1:0] w;
        w = EW'(t[FW-1:3]);
        if (w > EW'({TMO_OUT_W{1'b1}})) begin
            tmo_view = {TMO_OUT_W{1'b1}};
        end else begin
            tmo_view = w[TMO_OUT_W-1:0];
        end
    endfunction

    // registers and next values
    logic [2:0]          r_state,    n_state;
    logic [FLIGHT_W-1:0] r_win,      n_win;
    logic [15:0]         r_fixed,    n_fixed;
    logic                r_dyn,      n_dyn;
    logic [7:0]          r_maxt,     n_maxt;
    logic [SEQ_W-1:0]    r_base_m1,  n_base_m1;
    logic [SEQ_W-1:0]    r_next,     n_next;
    logic [FLIGHT_W-1:0] r_flight,   n_flight;
    logic [TW-1:0]       r_elapsed,  n_elapsed;
    logic [FW-1:0]       r_tmo,      n_tmo;
    logic                r_running,  n_running;
    logic                r_sampling, n_sampling;
    logic [TW-1:0]       r_rtt_el,   n_rtt_el;
    logic [FW-1:0]       r_est,      n_est;
    logic [FW-1:0]       r_dev,      n_dev;
    logic [FW-1:0]       r_diff,     n_diff;
    logic [7:0]          r_retry,    n_retry;
    logic                r_aborted,  n_aborted;
    logic [FLIGHT_W-1:0] r_idx,      n_idx;
    logic [FLIGHT_W-1:0] r_cnt,      n_cnt;
    logic                r_out_vld,  n_out_vld;
    t_out_item           r_out,      n_out;

    // datapath helpers
    logic                w_out_free;
    logic                w_pop;
    logic                w_abort;
    logic [FLIGHT_W-1:0] w_win_eff;
    logic [SEQ_W-1:0]    w_ack_dist;
    logic                w_ack_ok;
    logic [FLIGHT_W-1:0] w_ack_flight;
    logic [TW-1:0]       w_t3;
    logic                w_fire;
    logic [FW-1:0]       w_sample;
    logic [FW+2:0]       w_est_sum;
    logic [FW+1:0]       w_dev_sum;
    logic [FW+2:0]       w_tmo_sum;

    assign w_out_free   = !r_out_vld || !i_out_stall;
    assign w_pop        = (r_state == ST_IDLE) && i_head.vld && w_out_free;
    assign o_pop        = w_pop;
    assign o_out_valid  = r_out_vld;
    assign o_out_data   = r_out;

    assign w_abort      = r_aborted || (r_retry > r_maxt);
    assign w_win_eff    = (r_win == '0) ? FLIGHT_W'(1) :
                          ((r_win > WIN_LIMIT) ? WIN_LIMIT : r_win);
    // ack+1-base == ack-(base-1)
    assign w_ack_dist   = i_head.ev.ack_seq - r_base_m1;
    assign w_ack_ok     = (w_ack_dist <= SEQ_W'(r_flight));
    assign w_ack_flight = r_flight - w_ack_dist[FLIGHT_W-1:0];
    // elapsed+1 exceeds timeout/8 unless the counter is already saturated
    assign w_t3         = r_tmo[FW-1:3];
    assign w_fire       = r_running &&
                          ((r_elapsed == TICK_MAX) ? (r_elapsed > w_t3) : (r_elapsed >= w_t3));

    // RTT filter terms, one per sequencer step
    assign w_sample  = {r_rtt_el, 3'b000};
    assign w_est_sum = {r_est, 3'b000} - {3'b000, r_est} + {3'b000, w_sample};
    assign w_dev_sum = {1'b0, r_dev, 1'b0} + {2'b00, r_dev} + {2'b00, r_diff};
    assign w_tmo_sum = {3'b000, r_est} + {1'b0, r_dev, 2'b00};

    // next-state logic
    always_comb begin
        n_state    = r_state;
        n_win      = r_win;
        n_fixed    = r_fixed;
        n_dyn      = r_dyn;
        n_maxt     = r_maxt;
        n_base_m1  = r_base_m1;
        n_next     = r_next;
        n_flight   = r_flight;
        n_elapsed  = r_elapsed;
        n_tmo      = r_tmo;
        n_running  = r_running;
        n_sampling = r_sampling;
        n_rtt_el   = r_rtt_el;
        n_est      = r_est;
        n_dev      = r_dev;
        n_diff     = r_diff;
        n_retry    = r_retry;
        n_aborted  = r_aborted;
        n_idx      = r_idx;
        n_cnt      = r_cnt;
        n_out_vld  = w_out_free ? 1'b0 : r_out_vld;
        n_out      = r_out;

        case (r_state)
            ST_IDLE: begin
                if (w_pop) begin
                    n_out_vld           = 1'b1;
                    n_out.kind          = KIND_NONE;
                    n_out.seq_out       = '0;
                    n_out.last          = 1'b1;
                    n_out.timeout_now   = tmo_view(r_tmo);
                    n_out.in_flight     = r_flight;
                    if (w_abort) begin
                        n_aborted  = 1'b1;
                        n_out.kind = KIND_ABORT;
                    end else if (i_head.ev.is_offer) begin
                        if (r_flight < w_win_eff) begin
                            if (r_dyn && !r_sampling) begin
                                n_sampling = 1'b1;
                                n_rtt_el   = '0;
                            end
                            if (r_flight == '0) begin
                                n_running = 1'b1;
                                n_elapsed = '0;
                            end
                            n_next          = r_next + 1'b1;
                            n_flight        = r_flight + 1'b1;
                            n_out.kind      = KIND_NEW;
                            n_out.seq_out   = r_next;
                            n_out.in_flight = r_flight + 1'b1;
                        end else begin
                            n_out.kind = KIND_FULL;
                        end
                    end else if (i_head.ev.is_ack) begin
                        if (w_ack_ok) begin
                            n_base_m1       = i_head.ev.ack_seq;
                            n_flight        = w_ack_flight;
                            n_retry         = '0;
                            n_elapsed       = '0;
                            n_running       = (w_ack_flight != '0);
                            n_out.in_flight = w_ack_flight;
                            // closing an RTT sample defers the result
                            if (r_dyn && r_sampling) begin
                                n_sampling = 1'b0;
                                n_out_vld  = 1'b0;
                                n_state    = ST_EST;
                            end
                        end
                    end else if (i_head.ev.is_tick) begin
                        if (r_sampling && (r_rtt_el != TICK_MAX)) begin
                            n_rtt_el = r_rtt_el + 1'b1;
                        end
                        if (r_running && (r_elapsed != TICK_MAX)) begin
                            n_elapsed = r_elapsed + 1'b1;
                        end
                        // timeout: back off in dynamic mode, count the retry, resend the window
                        if (w_fire) begin
                            if (r_dyn) begin
                                n_tmo = r_tmo[FW-1] ? FRAC_MAX : {r_tmo[FW-2:0], 1'b0};
                            end
                            if (r_retry != 8'hFF) begin
                                n_retry = r_retry + 1'b1;
                            end
                            n_elapsed = '0;
                            if (r_dyn && !r_sampling) begin
                                n_sampling = 1'b1;
                                n_rtt_el   = '0;
                            end
                            n_cnt     = r_flight;
                            n_idx     = FLIGHT_W'(1);
                            n_out_vld = 1'b0;
                            n_state   = ST_RESEND;
                        end
                    end
                end
            end
            ST_EST: begin
                n_est   = w_est_sum[FW+2:3];
                n_state = ST_DIFF;
            end
            ST_DIFF: begin
                n_diff  = (w_sample > r_est) ? (w_sample - r_est) : (r_est - w_sample);
                n_state = ST_DEV;
            end
            ST_DEV: begin
                n_dev   = w_dev_sum[FW+1:2];
                n_state = ST_TMO;
            end
            ST_TMO: begin
                n_tmo   = (|w_tmo_sum[FW+2:FW]) ? FRAC_MAX : w_tmo_sum[FW-1:0];
                n_state = ST_ACKOUT;
            end
            ST_ACKOUT: begin
                if (w_out_free) begin
                    n_out_vld         = 1'b1;
                    n_out.kind        = KIND_NONE;
                    n_out.seq_out     = '0;
                    n_out.last        = 1'b1;
                    n_out.timeout_now = tmo_view(r_tmo);
                    n_out.in_flight   = r_flight;
                    n_state           = ST_IDLE;
                end
            end
            ST_RESEND: begin
                if (w_out_free) begin
                    n_out_vld         = 1'b1;
                    n_out.timeout_now = tmo_view(r_tmo);
                    n_out.in_flight   = r_flight;
                    if (r_cnt == '0) begin
                        n_out.kind    = KIND_NONE;
                        n_out.seq_out = '0;
                        n_out.last    = 1'b1;
                        n_state       = ST_IDLE;
                    end else begin
                        n_out.kind    = KIND_RESEND;
                        n_out.seq_out = r_base_m1 + SEQ_W'(r_idx);
                        n_out.last    = (r_idx == r_cnt);
                        n_idx         = r_idx + 1'b1;
                        if (r_idx == r_cnt) begin
                            n_state = ST_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // register writes; timeout reloads for the new mode
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_WINDOW: begin
                    n_win = i_cfg_data[FLIGHT_W-1:0];
                end
                CFG_FIXED: begin
                    n_fixed = i_cfg_data;
                    n_tmo   = reload_value(r_dyn, i_cfg_data);
                end
                CFG_DYNAMIC: begin
                    n_dyn = i_cfg_data[0];
                    n_tmo = reload_value(i_cfg_data[0], r_fixed);
                end
                CFG_TRIALS: begin
                    n_maxt = i_cfg_data[7:0];
                end
                default: begin
                    n_win = r_win;
                end
            endcase
        end
    end

    // control and protocol state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_win      <= RST_WINDOW;
            r_fixed    <= RST_FIXED;
            r_dyn      <= 1'b0;
            r_maxt     <= RST_TRIALS;
            r_base_m1  <= '1;
            r_next     <= '0;
            r_flight   <= '0;
            r_elapsed  <= '0;
            r_tmo      <= reload_value(1'b0, RST_FIXED);
            r_running  <= 1'b0;
            r_sampling <= 1'b0;
            r_rtt_el   <= '0;
            r_est      <= '0;
            r_dev      <= '0;
            r_retry    <= '0;
            r_aborted  <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_win      <= n_win;
            r_fixed    <= n_fixed;
            r_dyn      <= n_dyn;
            r_maxt     <= n_maxt;
            r_base_m1  <= n_base_m1;
            r_next     <= n_next;
            r_flight   <= n_flight;
            r_elapsed  <= n_elapsed;
            r_tmo      <= n_tmo;
            r_running  <= n_running;
            r_sampling <= n_sampling;
            r_rtt_el   <= n_rtt_el;
            r_est      <= n_est;
            r_dev      <= n_dev;
            r_retry    <= n_retry;
            r_aborted  <= n_aborted;
            r_out_vld  <= n_out_vld;
        end
    end

    // payload and scratch registers
    always_ff @(posedge i_clk) begin
        r_diff <= n_diff;
        r_idx  <= n_idx;
        r_cnt  <= n_cnt;
        r_out  <= n_out;
    end

endmodule

`default_nettype wire

// ===== rtl/go_back_n_sender_rtt_unit.sv =====
// Top level of the go-back-n sender control with RTT-based timeout.
// Input channel: one event per transaction (offer, cumulative ack, tick), accepted
//   when i_in_valid is high and o_in_stall is low. Results leave on the output
//   channel under i_out_stall, one transaction per result item; last marks the
//   final result of an event.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index at once;
//   write only while no event is pending.
// Ordering: an event is queued, then popped by the back end into its result
//   register. An ack that closes an RTT sample first passes the estimate,
//   difference, deviation and timeout steps of the back-end sequencer.
// Throughput: one event per cycle for offers, ticks without timeout and acks that
//   close no sample, while the output is not stalled; an RTT-closing ack holds the
//   back end through those steps; a timeout emits one resend per cycle, set by the
//   single result register, while the output is not stalled.
// Reset: synchronous, active low; all window, timer and RTT state clears and the
//   registers take their default values; no clearing pass follows.
// Stall: a stalled result holds in the output register, the back end waits, the
//   four-entry event queue fills, and then o_in_stall rises.
`default_nettype none
`include "go_back_n_sender_rtt_unit_defines.svh"

module go_back_n_sender_rtt_unit #(
    parameter int WINDOW_MAX = 64,
    parameter int TIMER_BITS = 24
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  gbn_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output gbn_pkg::t_out_item              o_out_data,
    input  logic                            i_cfg_we,
    input  logic [gbn_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gbn_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import gbn_pkg::*;

    t_queue_head w_head;
    logic        w_pop;

    // event decode and queue
    gbn_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_head     (w_head),
        .i_pop      (w_pop)
    );

    // protocol state and result generation
    gbn_back #(
        .WINDOW_MAX (WINDOW_MAX),
        .TIMER_BITS (TIMER_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // checks
    `GBN_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, w_pop, w_head.vld)
    `GBN_ASSERT_IMP(a_flight_bound, i_clk, i_rst_n, o_out_valid, o_out_data.in_flight <= 7'(WINDOW_MAX))
    `GBN_ASSERT_IMP(a_abort_form, i_clk, i_rst_n, o_out_valid && o_out_data.kind == KIND_ABORT, o_out_data.last && o_out_data.seq_out == '0)
    `GBN_ASSERT_NXT(a_resend_burst, i_clk, i_rst_n, o_out_valid && !i_out_stall && o_out_data.kind == KIND_RESEND && !o_out_data.last, o_out_valid && o_out_data.kind == KIND_RESEND)

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the go-back-n sender control: directed table, then random events.
`timescale 1ns / 1ps

module tb;
    import gbn_pkg::*;

    // opcode the block must treat as a no-op
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 10;

    // one row of the directed table: a register write or an event
    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  cfg_idx;
        logic [CFG_DATA_W-1:0] cfg_val;
        logic [1:0]            op;
        logic [SEQ_W-1:0]      ack;
        logic                  typed;
        logic [2:0]            kind;
        logic [SEQ_W-1:0]      seq;
        logic [TMO_OUT_W-1:0]  tmo;
        logic [FLIGHT_W-1:0]   fl;
    } t_step;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    go_back_n_sender_rtt_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // sender mirror: registers
    logic [6:0]  cfg_window;
    logic [15:0] cfg_fixed;
    logic        cfg_dyn;
    logic [7:0]  cfg_trials;

    // sender mirror: window, timer and RTT state
    logic [31:0] win_base, next_seq;
    logic [23:0] elapsed, rtt_ticks;
    logic [26:0] tmo_frac, rtt_est, rtt_dev;
    logic        timer_on, sampling, gave_up;
    logic [7:0]  retries;

    t_out_item step_results[$];
    t_out_item owed_reports[$];
    int        err_count = 0;

    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;
    int stall_left  = 0;
    int free_left   = 0;
    int idle_cycles = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [26:0] sat27(longint unsigned v);
        return (v > 64'h7FF_FFFF) ? 27'h7FF_FFFF : v[26:0];
    endfunction

    function void reload_timeout();
        tmo_frac = {8'd0, (cfg_dyn ? START_TIMEOUT : cfg_fixed), 3'b000};
    endfunction

    function void clear_sender();
        cfg_window = RST_WINDOW;
        cfg_fixed  = RST_FIXED;
        cfg_dyn    = 1'b0;
        cfg_trials = RST_TRIALS;
        win_base   = '0;
        next_seq   = '0;
        elapsed    = '0;
        rtt_ticks  = '0;
        rtt_est    = '0;
        rtt_dev    = '0;
        timer_on   = 1'b0;
        sampling   = 1'b0;
        gave_up    = 1'b0;
        retries    = '0;
        reload_timeout();
    endfunction

    function void apply_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_WINDOW: cfg_window = val[6:0];
            CFG_FIXED: begin
                cfg_fixed = val;
                reload_timeout();
            end
            CFG_DYNAMIC: begin
                cfg_dyn = val[0];
                reload_timeout();
            end
            CFG_TRIALS: cfg_trials = val[7:0];
            default: ;
        endcase
    endfunction

    // one result as seen after the event's state update
    function void emit_result(logic [2:0] kind, logic [31:0] seq);
        t_out_item r;
        logic [31:0] d;
        d = next_seq - win_base;
        r.kind        = kind;
        r.seq_out     = seq;
        r.last        = 1'b0;
        r.timeout_now = tmo_frac[26:3];
        r.in_flight   = d[6:0];
        step_results.push_back(r);
    endfunction

    function void open_sample();
        if (cfg_dyn && !sampling) begin
            sampling  = 1'b1;
            rtt_ticks = '0;
        end
    endfunction

    // Jacobson update, values in eighths of a tick
    function void close_sample();
        longint unsigned s, e, d, diff;
        s = longint'(rtt_ticks) << 3;
        e = rtt_est;
        d = rtt_dev;
        e = sat27((7 * e + s) >> 3);
        diff = (s > e) ? s - e : e - s;
        d = sat27((3 * d + diff) >> 2);
        rtt_est  = e[26:0];
        rtt_dev  = d[26:0];
        tmo_frac = sat27(e + 4 * d);
        sampling = 1'b0;
    endfunction

    // predicts the results of one accepted event into step_results
    function void advance_sender(t_in_item ev);
        logic [31:0] fl, nb, cnt;
        int unsigned win;
        t_out_item   tail;
        step_results.delete();
        fl = next_seq - win_base;
        if (gave_up || retries > cfg_trials) begin
            gave_up = 1'b1;
            emit_result(KIND_ABORT, '0);
        end else begin
            case (ev.opcode)
                OP_OFFER: begin
                    win = (cfg_window == 0) ? 1 : ((cfg_window > 64) ? 64 : cfg_window);
                    if (fl < win) begin
                        open_sample();
                        if (win_base == next_seq) begin
                            timer_on = 1'b1;
                            elapsed  = '0;
                        end
                        next_seq = next_seq + 1;
                        emit_result(KIND_NEW, next_seq - 1);
                    end else begin
                        emit_result(KIND_FULL, '0);
                    end
                end
                OP_ACK: begin
                    nb = ev.ack_seq + 1;
                    if (nb - win_base <= fl) begin
                        win_base = nb;
                        retries  = '0;
                        if (cfg_dyn && sampling) close_sample();
                        elapsed  = '0;
                        timer_on = (win_base != next_seq);
                    end
                    emit_result(KIND_NONE, '0);
                end
                OP_TICK: begin
                    if (sampling && rtt_ticks != '1) rtt_ticks = rtt_ticks + 1;
                    if (timer_on && elapsed != '1) elapsed = elapsed + 1;
                    if (timer_on && {elapsed, 3'b000} > tmo_frac) begin
                        // timeout: back off in dynamic mode, count the retry, resend the window
                        if (cfg_dyn) tmo_frac = sat27(2 * longint'(tmo_frac));
                        if (retries != 8'hFF) retries = retries + 1;
                        elapsed = '0;
                        open_sample();
                        cnt = (fl > 64) ? 64 : fl;
                        if (cnt == 0) begin
                            emit_result(KIND_NONE, '0);
                        end else begin
                            for (int i = 0; i < cnt; i++) emit_result(KIND_RESEND, win_base + i);
                        end
                    end else begin
                        emit_result(KIND_NONE, '0);
                    end
                end
                default: emit_result(KIND_NONE, '0);
            endcase
        end
        tail = step_results.pop_back();
        tail.last = 1'b1;
        step_results.push_back(tail);
    endfunction

    // random event; acks mostly land inside the current window
    function automatic t_in_item make_event();
        t_in_item    ev;
        int          r;
        logic [31:0] fl;
        fl = next_seq - win_base;
        r = $urandom_range(0, 99);
        ev.ack_seq = $urandom();
        if (r < 35) begin
            ev.opcode = OP_OFFER;
        end else if (r < 60) begin
            ev.opcode = OP_ACK;
            if ($urandom_range(0, 99) < 85) ev.ack_seq = win_base - 1 + $urandom_range(0, fl);
        end else if (r < 95) begin
            ev.opcode = OP_TICK;
        end else begin
            ev.opcode = OP_UNUSED;
        end
        return ev;
    endfunction

    function automatic t_step ev_row(logic [1:0] op, logic [31:0] ack);
        t_step s;
        s = '0;
        s.op  = op;
        s.ack = ack;
        return s;
    endfunction

    function automatic t_step chk_row(logic [1:0] op, logic [31:0] ack, logic [2:0] kind,
                                      logic [31:0] seq, logic [23:0] tmo, logic [6:0] fl);
        t_step s;
        s = ev_row(op, ack);
        s.typed = 1'b1;
        s.kind  = kind;
        s.seq   = seq;
        s.tmo   = tmo;
        s.fl    = fl;
        return s;
    endfunction

    function automatic t_step cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        t_step s;
        s = '0;
        s.is_cfg  = 1'b1;
        s.cfg_idx = idx;
        s.cfg_val = val;
        return s;
    endfunction

    // let every owed result arrive and the back end settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (owed_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        apply_config(idx, val);
        i_cfg_we    <= 1'b0;
    endtask

    // offer one event, wait for the transaction, then book its results
    task automatic send_event(t_in_item ev, logic typed, t_out_item typed_res);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= ev;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        advance_sender(ev);
        if (typed) owed_reports.push_back(typed_res);
        else foreach (step_results[k]) owed_reports.push_back(step_results[k]);
    endtask

    // stimulus
    initial begin : stimulus
        t_step       plan[$];
        t_in_item    ev;
        t_out_item   res;
        int          n_items;
        logic [15:0] w, f, d, t;

        clear_sender();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part: reset values, window extremes, timeout, RTT sample, no-op opcode
        plan.push_back(chk_row(OP_TICK, 32'd0, KIND_NONE, 32'd0, 24'd50, 7'd0));
        plan.push_back(chk_row(OP_ACK, 32'hFFFF_FFFF, KIND_NONE, 32'd0, 24'd50, 7'd0));
        plan.push_back(chk_row(OP_ACK, 32'd5, KIND_NONE, 32'd0, 24'd50, 7'd0));
        plan.push_back(cfg_row(CFG_FIXED, 16'd1));
        plan.push_back(cfg_row(CFG_WINDOW, 16'd0));
        plan.push_back(chk_row(OP_OFFER, 32'hFFFF_FFFF, KIND_NEW, 32'd0, 24'd1, 7'd1));
        plan.push_back(chk_row(OP_OFFER, 32'd0, KIND_FULL, 32'd0, 24'd1, 7'd1));
        plan.push_back(chk_row(OP_TICK, 32'd0, KIND_NONE, 32'd0, 24'd1, 7'd1));
        plan.push_back(chk_row(OP_TICK, 32'd0, KIND_RESEND, 32'd0, 24'd1, 7'd1));
        plan.push_back(cfg_row(CFG_WINDOW, 16'd127));
        plan.push_back(chk_row(OP_OFFER, 32'd0, KIND_NEW, 32'd1, 24'd1, 7'd2));
        plan.push_back(ev_row(OP_OFFER, 32'd0));
        plan.push_back(ev_row(OP_TICK, 32'd0));
        plan.push_back(ev_row(OP_TICK, 32'd0));
        plan.push_back(ev_row(OP_ACK, 32'd0));
        plan.push_back(cfg_row(CFG_DYNAMIC, 16'd1));
        plan.push_back(ev_row(OP_OFFER, 32'd0));
        plan.push_back(ev_row(OP_TICK, 32'd0));
        plan.push_back(ev_row(OP_TICK, 32'd0));
        plan.push_back(ev_row(OP_ACK, 32'd3));
        plan.push_back(ev_row(OP_UNUSED, 32'hFFFF_FFFF));
        plan.push_back(ev_row(OP_OFFER, 32'd0));
        plan.push_back(ev_row(OP_TICK, 32'd0));
        plan.push_back(ev_row(OP_TICK, 32'd0));
        plan.push_back(cfg_row(CFG_TRIALS, 16'd255));
        plan.push_back(cfg_row(CFG_FIXED, 16'hFFFF));
        plan.push_back(cfg_row(CFG_DYNAMIC, 16'd0));
        plan.push_back(ev_row(OP_TICK, 32'd0));

        foreach (plan[k]) begin
            if (plan[k].is_cfg) begin
                cfg_write(plan[k].cfg_idx, plan[k].cfg_val);
            end else begin
                ev.opcode  = plan[k].op;
                ev.ack_seq = plan[k].ack;
                res.kind        = plan[k].kind;
                res.seq_out     = plan[k].seq;
                res.last        = 1'b1;
                res.timeout_now = plan[k].tmo;
                res.in_flight   = plan[k].fl;
                send_event(ev, plan[k].typed, res);
            end
        end

        // random phases; the last one drops the retry budget to zero
        res = '0;
        for (int p = 0; p < 4; p++) begin
            // full ack clears the retry count before new settings
            drain();
            ev.opcode  = OP_ACK;
            ev.ack_seq = next_seq - 1;
            send_event(ev, 1'b0, res);
            case (p)
                0: begin w = 16'd1;  f = 16'd2; d = 16'd0; t = 16'd255; n_items = 20; end
                1: begin w = 16'd64; f = 16'd3; d = 16'd1; t = 16'd255; n_items = 25; end
                2: begin
                    w = $urandom_range(0, 127);
                    f = $urandom_range(1, 6);
                    d = $urandom_range(0, 1);
                    t = $urandom_range(200, 255);
                    n_items = 20;
                end
                default: begin w = 16'd8; f = 16'd1; d = 16'd0; t = 16'd0; n_items = 15; end
            endcase
            cfg_write(CFG_WINDOW, w);
            cfg_write(CFG_FIXED, f);
            cfg_write(CFG_DYNAMIC, d);
            cfg_write(CFG_TRIALS, t);
            // receiver holds off while the sender keeps offering
            if (p == 1) hold_req = 1'b1;
            repeat (n_items) send_event(make_event(), 1'b0, res);
        end

        drain();
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // receiver pacing: short and long stalls, free-running stretches, one long hold-off
    always @(posedge i_clk) begin : out_pacing
        if (hold_req && !hold_done) begin
            hold_done   <= 1'b1;
            stall_left  <= HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (free_left > 0) begin
            free_left   <= free_left - 1;
            i_out_stall <= 1'b0;
        end else begin
            stall_left  <= pick_gap();
            free_left   <= ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                      : $urandom_range(1, 8);
            i_out_stall <= 1'b0;
        end
    end

    // result checker
    always @(posedge i_clk) begin : result_check
        t_out_item want, got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = o_out_data;
            if (owed_reports.size() == 0) begin
                $error("unexpected result: kind %0d seq_out %0d", got.kind, got.seq_out);
                err_count++;
            end else begin
                want = owed_reports.pop_front();
                if (got.kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, got.kind);
                    err_count++;
                end
                if (got.seq_out !== want.seq_out) begin
                    $error("seq_out: expected %0d, got %0d", want.seq_out, got.seq_out);
                    err_count++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    err_count++;
                end
                if (got.timeout_now !== want.timeout_now) begin
                    $error("timeout_now: expected %0d, got %0d",
                           want.timeout_now, got.timeout_now);
                    err_count++;
                end
                if (got.in_flight !== want.in_flight) begin
                    $error("in_flight: expected %0d, got %0d", want.in_flight, got.in_flight);
                    err_count++;
                end
            end
        end
    end

    // watchdog: too long without any transaction on either channel
    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
